// ----- src/hsv2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared beat types, hue sector codes and fixed-point constants for the
// 8-bit HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // Input beat: hue in whole degrees, saturation and value on 8 bits.
  typedef struct packed {
    logic [8:0] hue;
    logic [7:0] saturation;
    logic [7:0] value;
  } hsv_t;

  // Output beat: one 8-bit intensity per color channel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // The six 60-degree hue sectors.
  typedef enum logic [2:0] {
    SECT_RED_YELLOW    = 3'd0,
    SECT_YELLOW_GREEN  = 3'd1,
    SECT_GREEN_CYAN    = 3'd2,
    SECT_CYAN_BLUE     = 3'd3,
    SECT_BLUE_MAGENTA  = 3'd4,
    SECT_MAGENTA_RED   = 3'd5
  } sector_e;

  localparam logic [8:0]  HueMax     = 9'd360;
  localparam logic [5:0]  RampFull   = 6'd60;

  // floor(n / 15300) == (n * RecipMul) >> RecipShift for every n below 2^22.
  localparam logic [22:0] RecipMul   = 23'd4491470;
  localparam int unsigned RecipShift = 36;

endpackage

// ----- src/hsv_to_rgb_converter.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Pipelined 8-bit HSV to RGB color conversion, one color per clock while the output is not stalled.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake                 | Beat type         | Direction
//   --------+---------------------------+-------------------+----------
//   in      | in_valid_i / in_ready_o   | hsv2rgb_pkg::hsv_t| into block
//   out     | out_valid_o / out_ready_i | hsv2rgb_pkg::rgb_t| out of block
//
// A color passes four register stages. The edge that accepts it loads the
// first stage; it then moves through stages 2 and 3 into the output register,
// stage 4, which drives out_valid_o. A new beat may enter whenever in_ready_o
// is high; throughput is one beat per clock while out_ready_i stays high.
// Reset (rst_ni low, asynchronous) clears only the four stage valid bits; the
// data registers carry no reset.
// Every stage has its own valid bit and loads when it is empty or when the
// stage after it moves on, so a stalled output holds its beat while bubbles
// further up the pipeline still fill in; nothing is dropped or repeated.
//
// Stages:
//   1. Clamp the hue to 360, find the sector and the ramp weight w (0..60).
//   2. Two 8x8 products: a = v*(255-s) and b = v*s.
//   3. Ramp numerator a*60 + b*w and the minimum channel floor(a/255).
//   4. Divide the numerator by 15300 through a reciprocal multiply and route
//      maximum, minimum and ramp onto red, green and blue by sector.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hsv2rgb_pkg::hsv_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hsv2rgb_pkg::rgb_t out_data_o
);

  // Valid bits and per-stage load enables.
  logic valid1_q, valid2_q, valid3_q, valid4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  // A stage may load when it is empty or its contents move on this cycle.
  assign rdy4 = !valid4_q || out_ready_i;
  assign rdy3 = !valid3_q || rdy4;
  assign rdy2 = !valid2_q || rdy3;
  assign rdy1 = !valid1_q || rdy2;

  assign in_ready_o  = rdy1;
  assign out_valid_o = valid4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
      valid3_q <= 1'b0;
      valid4_q <= 1'b0;
    end else begin
      if (rdy1) valid1_q <= in_valid_i;
      if (rdy2) valid2_q <= valid1_q;
      if (rdy3) valid3_q <= valid2_q;
      if (rdy4) valid4_q <= valid3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: sector and ramp weight.
  // --------------------------------------------------------------------------
  // The ramp weight is 60 - |hue mod 120 - 60|. In even sectors that is the
  // offset into the sector, in odd sectors it is 60 minus the offset. Hue 360
  // lands in the last sector with offset 60, which gives a weight of zero.
  logic [8:0]           hue_clamped;
  hsv2rgb_pkg::sector_e sector_d;
  logic [8:0]           offset_wide;
  logic [5:0]           offset;
  logic [5:0]           weight_d;

  hsv2rgb_pkg::sector_e sector1_q;
  logic [5:0]           weight1_q;
  logic [7:0]           sat1_q, val1_q;

  always_comb begin
    hue_clamped = (in_data_i.hue > hsv2rgb_pkg::HueMax) ? hsv2rgb_pkg::HueMax
                                                        : in_data_i.hue;
    if (hue_clamped >= 9'd300) begin
      sector_d    = hsv2rgb_pkg::SECT_MAGENTA_RED;
      offset_wide = hue_clamped - 9'd300;
    end else if (hue_clamped >= 9'd240) begin
      sector_d    = hsv2rgb_pkg::SECT_BLUE_MAGENTA;
      offset_wide = hue_clamped - 9'd240;
    end else if (hue_clamped >= 9'd180) begin
      sector_d    = hsv2rgb_pkg::SECT_CYAN_BLUE;
      offset_wide = hue_clamped - 9'd180;
    end else if (hue_clamped >= 9'd120) begin
      sector_d    = hsv2rgb_pkg::SECT_GREEN_CYAN;
      offset_wide = hue_clamped - 9'd120;
    end else if (hue_clamped >= 9'd60) begin
      sector_d    = hsv2rgb_pkg::SECT_YELLOW_GREEN;
      offset_wide = hue_clamped - 9'd60;
    end else begin
      sector_d    = hsv2rgb_pkg::SECT_RED_YELLOW;
      offset_wide = hue_clamped;
    end
    offset   = offset_wide[5:0];
    // Odd sectors ramp downward.
    weight_d = sector_d[0] ? (hsv2rgb_pkg::RampFull - offset) : offset;
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      sector1_q <= sector_d;
      weight1_q <= weight_d;
      sat1_q    <= in_data_i.saturation;
      val1_q    <= in_data_i.value;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: the two 8x8 products.
  // --------------------------------------------------------------------------
  logic [15:0]          prod_a_d, prod_b_d;
  logic [15:0]          prod_a2_q, prod_b2_q;
  hsv2rgb_pkg::sector_e sector2_q;
  logic [5:0]           weight2_q;
  logic [7:0]           val2_q;

  assign prod_a_d = {8'd0, val1_q} * {8'd0, 8'd255 - sat1_q};
  assign prod_b_d = {8'd0, val1_q} * {8'd0, sat1_q};

  always_ff @(posedge clk_i) begin
    if (rdy2 && valid1_q) begin
      prod_a2_q <= prod_a_d;
      prod_b2_q <= prod_b_d;
      sector2_q <= sector1_q;
      weight2_q <= weight1_q;
      val2_q    <= val1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: ramp numerator and minimum channel.
  // --------------------------------------------------------------------------
  // The numerator a*60 + b*w peaks at 255*255*60, which fits 22 bits. The
  // minimum floor(a/255) uses (a + 1 + (a >> 8)) >> 8, exact for a up to 255*255.
  logic [21:0]          a_times_60;
  logic [21:0]          b_times_w;
  logic [21:0]          numer_d;
  logic [16:0]          lo_sum;
  logic [7:0]           lo_d;

  logic [21:0]          numer3_q;
  logic [7:0]           lo3_q;
  hsv2rgb_pkg::sector_e sector3_q;
  logic [7:0]           val3_q;

  always_comb begin
    a_times_60 = ({6'd0, prod_a2_q} << 6) - ({6'd0, prod_a2_q} << 2);
    b_times_w  = {6'd0, prod_b2_q} * {16'd0, weight2_q};
    numer_d    = a_times_60 + b_times_w;
    lo_sum     = {1'b0, prod_a2_q} + 17'd1 + {9'd0, prod_a2_q[15:8]};
    lo_d       = lo_sum[15:8];
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && valid2_q) begin
      numer3_q  <= numer_d;
      lo3_q     <= lo_d;
      sector3_q <= sector2_q;
      val3_q    <= val2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: divide by 15300 and route the channels.
  // --------------------------------------------------------------------------
  logic [44:0]       recip_prod;
  logic [7:0]        mid;
  hsv2rgb_pkg::rgb_t rgb_d;
  hsv2rgb_pkg::rgb_t rgb4_q;

  always_comb begin
    recip_prod = {23'd0, numer3_q} * {22'd0, hsv2rgb_pkg::RecipMul};
    mid        = recip_prod[hsv2rgb_pkg::RecipShift +: 8];
    unique case (sector3_q)
      hsv2rgb_pkg::SECT_RED_YELLOW:   rgb_d = '{red: val3_q, green: mid,    blue: lo3_q};
      hsv2rgb_pkg::SECT_YELLOW_GREEN: rgb_d = '{red: mid,    green: val3_q, blue: lo3_q};
      hsv2rgb_pkg::SECT_GREEN_CYAN:   rgb_d = '{red: lo3_q,  green: val3_q, blue: mid};
      hsv2rgb_pkg::SECT_CYAN_BLUE:    rgb_d = '{red: lo3_q,  green: mid,    blue: val3_q};
      hsv2rgb_pkg::SECT_BLUE_MAGENTA: rgb_d = '{red: mid,    green: lo3_q,  blue: val3_q};
      hsv2rgb_pkg::SECT_MAGENTA_RED:  rgb_d = '{red: val3_q, green: lo3_q,  blue: mid};
      default:                        rgb_d = '{red: val3_q, green: lo3_q,  blue: mid};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && valid3_q) begin
      rgb4_q <= rgb_d;
    end
  end

  assign out_data_o = rgb4_q;

endmodule
